// ===== rtl/arpd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// arpd_pkg
// shared types and constants of the response and payload demultiplexer
// ---------------------------------------------------------------------------
package arpd_pkg;

    localparam int KEY_W      = 64;
    localparam int KEY_LEN_W  = 4;
    localparam int LEN_MAX_W  = 20;
    localparam int ACCUM_W    = 24;
    localparam int SEEN_W     = 21;
    localparam int OVF_W      = 32;
    localparam int DEST_W     = 2;
    localparam int CFG_IDX_W  = 2;

    localparam logic [7:0] FRAME_SEP  = 8'h3A;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_NINE = 8'h39;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_MAX   = 2'd2;

    localparam logic [DEST_W-1:0] DEST_NONE    = 2'd0;
    localparam logic [DEST_W-1:0] DEST_RESP    = 2'd1;
    localparam logic [DEST_W-1:0] DEST_PAYLOAD = 2'd2;

    typedef enum logic [1:0] {
        MODE_RESP = 2'd0,
        MODE_LEN  = 2'd1,
        MODE_DATA = 2'd2
    } t_mode;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       resp_full;
        logic       payload_full;
    } t_item;

    typedef struct packed {
        logic [7:0][7:0]       key_bytes;
        logic [KEY_LEN_W-1:0]  key_length;
        logic [LEN_MAX_W-1:0]  len_max;
    } t_cfg;

    typedef struct packed {
        logic [DEST_W-1:0] dest;
        logic [7:0]        out_byte;
        logic              dropped;
        logic              done;
        logic              ferr;
        logic [OVF_W-1:0]  overflow;
    } t_result;

endpackage

// ===== rtl/arpd_engine.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// arpd_engine
// key matcher, length parser and payload counter for one byte per cycle while i_fire is high
// ---------------------------------------------------------------------------
module arpd_engine #(
    parameter int KEY_MAX      = 8,
    parameter int LEN_BUF_SIZE = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  arpd_pkg::t_item   i_item,
    input  arpd_pkg::t_cfg    i_cfg,
    output arpd_pkg::t_result o_result
);

    localparam int KIW = $clog2(KEY_MAX + 1);
    localparam int DCW = (LEN_BUF_SIZE > 2) ? $clog2(LEN_BUF_SIZE) : 1;
    localparam logic [DCW-1:0] DIGIT_LIMIT = DCW'(LEN_BUF_SIZE - 1);

    arpd_pkg::t_mode                  r_mode, n_mode;
    logic [KIW-1:0]                   r_key_index, n_key_index;
    logic [DCW-1:0]                   r_digit_count, n_digit_count;
    logic [arpd_pkg::ACCUM_W-1:0]     r_length_accum, n_length_accum;
    logic                             r_digits_ended, n_digits_ended;
    logic [arpd_pkg::SEEN_W-1:0]      r_payload_seen, n_payload_seen;
    logic [arpd_pkg::OVF_W-1:0]       r_overflow, n_overflow;

    logic [KIW-1:0]                   w_klen;
    logic [KIW-1:0]                   w_kidx;
    logic [KIW-1:0]                   w_kidx_next;
    logic [3:0]                       w_kidx_x;
    logic [7:0]                       w_key_char;
    logic                             w_is_digit;
    logic [arpd_pkg::SEEN_W-1:0]      w_seen_inc;

    // effective key length, clamped into 1..KEY_MAX
    always_comb begin
        if (i_cfg.key_length == '0) begin
            w_klen = KIW'(1);
        end else if (i_cfg.key_length > arpd_pkg::KEY_LEN_W'(KEY_MAX)) begin
            w_klen = KIW'(KEY_MAX);
        end else begin
            w_klen = i_cfg.key_length[KIW-1:0];
        end
    end

    assign w_kidx      = (r_key_index >= w_klen) ? '0 : r_key_index;
    assign w_kidx_x    = 4'(w_kidx);
    assign w_key_char  = i_cfg.key_bytes[w_kidx_x[2:0]];
    assign w_kidx_next = (w_key_char == i_item.rx_byte) ? w_kidx + KIW'(1) : '0;
    assign w_is_digit  = (i_item.rx_byte >= arpd_pkg::DIGIT_ZERO) &&
                         (i_item.rx_byte <= arpd_pkg::DIGIT_NINE);
    assign w_seen_inc  = (r_payload_seen != '1) ? r_payload_seen + 1'b1 : r_payload_seen;

    always_comb begin
        n_mode         = r_mode;
        n_key_index    = r_key_index;
        n_digit_count  = r_digit_count;
        n_length_accum = r_length_accum;
        n_digits_ended = r_digits_ended;
        n_payload_seen = r_payload_seen;
        n_overflow     = r_overflow;
        o_result       = '0;

        case (r_mode)
            arpd_pkg::MODE_LEN: begin
                if (i_item.rx_byte == arpd_pkg::FRAME_SEP) begin
                    if (r_length_accum > arpd_pkg::ACCUM_W'(i_cfg.len_max)) begin
                        o_result.ferr = 1'b1;
                        n_key_index   = '0;
                        n_mode        = arpd_pkg::MODE_RESP;
                    end else begin
                        n_payload_seen = '0;
                        n_mode         = arpd_pkg::MODE_DATA;
                    end
                end else if (r_digit_count >= DIGIT_LIMIT) begin
                    o_result.ferr = 1'b1;
                    n_key_index   = '0;
                    n_mode        = arpd_pkg::MODE_RESP;
                end else begin
                    if (!r_digits_ended && w_is_digit) begin
                        // times ten as two shifts, truncated to the accumulator
                        n_length_accum = (r_length_accum << 3) + (r_length_accum << 1)
                                       + arpd_pkg::ACCUM_W'(i_item.rx_byte
                                                             - arpd_pkg::DIGIT_ZERO);
                    end else begin
                        n_digits_ended = 1'b1;
                    end
                    n_digit_count = r_digit_count + 1'b1;
                end
            end
            arpd_pkg::MODE_DATA: begin
                n_payload_seen = w_seen_inc;
                if (arpd_pkg::ACCUM_W'(w_seen_inc) >= r_length_accum) begin
                    o_result.done = 1'b1;
                    n_key_index   = '0;
                    n_mode        = arpd_pkg::MODE_RESP;
                end
                if (i_item.payload_full) begin
                    n_overflow       = r_overflow + 1'b1;
                    o_result.dropped = 1'b1;
                end else begin
                    o_result.dest     = arpd_pkg::DEST_PAYLOAD;
                    o_result.out_byte = i_item.rx_byte;
                end
            end
            default: begin
                n_key_index = w_kidx_next;
                if (w_kidx_next == w_klen) begin
                    n_length_accum = '0;
                    n_digit_count  = '0;
                    n_digits_ended = 1'b0;
                    n_mode         = arpd_pkg::MODE_LEN;
                end else if (i_item.resp_full) begin
                    n_overflow       = r_overflow + 1'b1;
                    o_result.dropped = 1'b1;
                end else begin
                    o_result.dest     = arpd_pkg::DEST_RESP;
                    o_result.out_byte = i_item.rx_byte;
                end
            end
        endcase

        o_result.overflow = n_overflow;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= arpd_pkg::MODE_RESP;
            r_key_index    <= '0;
            r_digit_count  <= '0;
            r_length_accum <= '0;
            r_digits_ended <= 1'b0;
            r_payload_seen <= '0;
            r_overflow     <= '0;
        end else if (i_fire) begin
            r_mode         <= n_mode;
            r_key_index    <= n_key_index;
            r_digit_count  <= n_digit_count;
            r_length_accum <= n_length_accum;
            r_digits_ended <= n_digits_ended;
            r_payload_seen <= n_payload_seen;
            r_overflow     <= n_overflow;
        end
    end

    a_ovf_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire |=> r_overflow == $past(r_overflow) + arpd_pkg::OVF_W'($past(o_result.dropped)))
        else $error("overflow count out of step with drops");

    a_done_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_result.done |=> r_mode == arpd_pkg::MODE_RESP && r_key_index == '0)
        else $error("frame end did not return to response mode");

endmodule

// ===== rtl/at_response_payload_demux.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// at_response_payload_demux
// splits a received modem byte stream into response bytes and framed payload
// ---------------------------------------------------------------------------
//  channel   dir  handshake                      contents
//  s_axis    in   s_axis_tvalid / s_axis_tready  received byte and buffer-full flags
//  m_axis    out  m_axis_tvalid / m_axis_tready  routed byte, destination, status
//  cfg       in   i_cfg_we (no wait)             key, key length, payload length max
//
//  one byte per cycle while m_axis_tready is high; a request passes through the
//  input register and then leaves from the result register
//  the mode, key index and length state advance when a request moves from the
//  input register into the result register, so each byte sees the last one
//  synchronous active-low reset clears all control and presets the three registers
//  a stalled output holds both stages; the input side keeps taking requests
//  while either stage has room
// ---------------------------------------------------------------------------
module at_response_payload_demux #(
    parameter int KEY_MAX      = 8,
    parameter int LEN_BUF_SIZE = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // register write port
    input  logic                               i_cfg_we,
    input  logic [arpd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [arpd_pkg::KEY_W-1:0]         i_cfg_data,

    // received bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // rx_byte[7:0], resp_full, payload_full, zero pad

    // routed bytes
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // out_byte[7:0], dropped_full, frame_error,
                                       // overflow_total[31:0], zero pad
    output logic [1:0]  m_axis_tuser,  // dest
    output logic        m_axis_tlast   // payload_done
);

    // configuration registers
    arpd_pkg::t_cfg    r_cfg;

    // input stage
    logic              r_in_valid;
    arpd_pkg::t_item   r_in;

    // result stage
    logic              r_out_valid;
    arpd_pkg::t_result r_out;

    arpd_pkg::t_result w_result;
    logic              w_out_free;
    logic              w_advance;
    logic              w_accept;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // register writes, indexes past the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_bytes  <= '0;
            r_cfg.key_length <= arpd_pkg::KEY_LEN_W'(1);
            r_cfg.len_max    <= arpd_pkg::LEN_MAX_W'(2048);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                arpd_pkg::REG_KEY_BYTES: r_cfg.key_bytes  <= i_cfg_data;
                arpd_pkg::REG_KEY_LEN:   r_cfg.key_length <= i_cfg_data[arpd_pkg::KEY_LEN_W-1:0];
                arpd_pkg::REG_LEN_MAX:   r_cfg.len_max    <= i_cfg_data[arpd_pkg::LEN_MAX_W-1:0];
                default: ;
            endcase
        end
    end

    // input register, refills in the same cycle that it drains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.rx_byte      <= s_axis_tdata[7:0];
            r_in.resp_full    <= s_axis_tdata[8];
            r_in.payload_full <= s_axis_tdata[9];
        end
    end

    // per-byte decision and the state it carries
    arpd_engine #(
        .KEY_MAX      (KEY_MAX),
        .LEN_BUF_SIZE (LEN_BUF_SIZE)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_advance),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.dest;
    assign m_axis_tlast  = r_out.done;
    assign m_axis_tdata  = {6'b0, r_out.overflow, r_out.ferr, r_out.dropped, r_out.out_byte};

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while both stages are stalled");

    a_drop_no_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.dropped |-> r_out.dest == arpd_pkg::DEST_NONE)
        else $error("dropped byte still routed");

    a_ferr_no_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.ferr |-> r_out.dest == arpd_pkg::DEST_NONE && !r_out.done)
        else $error("frame error on a routed byte");

endmodule
